@@ rtl/ehx_pkg.sv @@
`default_nettype none

package ehx_pkg;

	// frame limits
	localparam int MAX_PAYLOAD     = 256;
	localparam int MAX_FRAME_BYTES = 16384;
	localparam int CNT_W           = $clog2(MAX_PAYLOAD + 1);
	localparam int OFF_W           = $clog2(MAX_FRAME_BYTES + 1);

	// header layout, byte offsets from frame start
	localparam int ETH_HDR_BYTES = 14;
	localparam int WORD_BYTES    = 4;
	localparam int MIN_IP_END    = 34;
	localparam int DMAC_END      = 6;
	localparam int SMAC_END      = 12;
	localparam int ETYPE_END     = 14;
	localparam int ETYPE_LO      = 13;
	localparam int IHL_OFF       = 14;
	localparam int PROTO_OFF     = 23;
	localparam int SIP_START     = 26;
	localparam int DIP_START     = 30;
	localparam int TCP_HDR_BYTES = 20;
	localparam int UDP_HDR_BYTES = 8;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [3:0]  MIN_IHL        = 4'd5;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_RECORD  = 1'b1
	} ehx_kind_t;

	typedef struct packed {
		logic             kind;
		logic [7:0]       payload_byte;
		logic [47:0]      dest_mac;
		logic [47:0]      source_mac;
		logic [15:0]      ethertype;
		logic [31:0]      source_ipv4;
		logic [31:0]      dest_ipv4;
		logic [15:0]      source_l4_port;
		logic [15:0]      dest_l4_port;
		logic [7:0]       ip_proto;
		logic [CNT_W-1:0] payload_length;
		logic             last;
	} ehx_result_t;

	// which of the two result slots carry an item this cycle
	typedef struct packed {
		logic first;
		logic second;
	} ehx_push_t;

endpackage

`default_nettype wire

@@ rtl/ehx_parse.sv @@
`default_nettype none

module ehx_parse
	import ehx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  byte_in,
	input  wire logic        eof,
	output ehx_push_t        push,
	output ehx_result_t      res_a,
	output ehx_result_t      res_b
);

	logic [OFF_W-1:0] off_q, off_n;
	logic             drop_q, drop_n;
	logic [47:0]      dmac_q, dmac_n;
	logic [47:0]      smac_q, smac_n;
	logic [15:0]      etype_q, etype_n;
	logic [3:0]       hw_q, hw_n;
	logic [7:0]       proto_q, proto_n;
	logic [31:0]      sip_q, sip_n;
	logic [31:0]      dip_q, dip_n;
	logic [15:0]      sport_q, sport_n;
	logic [15:0]      dport_q, dport_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;

	logic [OFF_W-1:0] tstart;
	logic [OFF_W-1:0] ps_cur;
	logic [OFF_W-1:0] ps_next;
	logic             ported;
	logic             pay_v;
	logic             rec_v;
	ehx_result_t      pay_res;
	ehx_result_t      rec_res;

	// offset where the payload begins, at least the end of the fixed ip header
	function automatic logic [OFF_W-1:0] pay_start(input logic [3:0] hw,
			input logic [7:0] proto);
		logic [OFF_W-1:0] p;
		p = OFF_W'(ETH_HDR_BYTES) + OFF_W'(hw) * OFF_W'(WORD_BYTES);
		if (proto == PROTO_TCP) begin
			p = p + OFF_W'(TCP_HDR_BYTES);
		end else if (proto == PROTO_UDP) begin
			p = p + OFF_W'(UDP_HDR_BYTES);
		end
		if (p < OFF_W'(MIN_IP_END)) begin
			p = OFF_W'(MIN_IP_END);
		end
		return p;
	endfunction

	assign tstart = OFF_W'(ETH_HDR_BYTES) + OFF_W'(hw_q) * OFF_W'(WORD_BYTES);
	assign ps_cur = pay_start(hw_q, proto_q);
	assign ported = (proto_q == PROTO_TCP) || (proto_q == PROTO_UDP);

	// header capture and payload selection for one byte
	always_comb begin
		off_n   = off_q;
		drop_n  = drop_q;
		dmac_n  = dmac_q;
		smac_n  = smac_q;
		etype_n = etype_q;
		hw_n    = hw_q;
		proto_n = proto_q;
		sip_n   = sip_q;
		dip_n   = dip_q;
		sport_n = sport_q;
		dport_n = dport_q;
		cnt_n   = cnt_q;
		pay_v   = 1'b0;
		if (off_q < OFF_W'(MAX_FRAME_BYTES)) begin
			off_n = off_q + OFF_W'(1);
			if (!drop_q) begin
				if (off_q < OFF_W'(DMAC_END)) begin
					dmac_n = {dmac_q[39:0], byte_in};
				end else if (off_q < OFF_W'(SMAC_END)) begin
					smac_n = {smac_q[39:0], byte_in};
				end else if (off_q < OFF_W'(ETYPE_END)) begin
					etype_n = {etype_q[7:0], byte_in};
					if (off_q == OFF_W'(ETYPE_LO) && {etype_q[7:0], byte_in} != ETHERTYPE_IPV4) begin
						drop_n = 1'b1;
					end
				end else if (off_q == OFF_W'(IHL_OFF)) begin
					hw_n = byte_in[3:0];
					if (byte_in[3:0] < MIN_IHL) begin
						drop_n = 1'b1;
					end
				end else if (off_q == OFF_W'(PROTO_OFF)) begin
					proto_n = byte_in;
				end else if (off_q >= OFF_W'(SIP_START) && off_q < OFF_W'(DIP_START)) begin
					sip_n = {sip_q[23:0], byte_in};
				end else if (off_q >= OFF_W'(DIP_START) && off_q < OFF_W'(MIN_IP_END)) begin
					dip_n = {dip_q[23:0], byte_in};
				end

				// transport ports and payload, past the fixed ip header
				if (!drop_n && off_q >= OFF_W'(MIN_IP_END)) begin
					if (ported && off_q >= tstart && off_q < tstart + OFF_W'(2)) begin
						sport_n = {sport_q[7:0], byte_in};
					end else if (ported && off_q >= tstart + OFF_W'(2)
							&& off_q < tstart + OFF_W'(4)) begin
						dport_n = {dport_q[7:0], byte_in};
					end
					if (off_q >= ps_cur && cnt_q < CNT_W'(MAX_PAYLOAD)) begin
						pay_v = 1'b1;
						cnt_n = cnt_q + CNT_W'(1);
					end
				end
			end
		end
	end

	// record is due when the headers it needs fit in the frame
	assign ps_next = pay_start(hw_n, proto_n);
	assign rec_v   = eof && !drop_n && off_n >= ps_next;

	always_comb begin
		pay_res              = '0;
		pay_res.kind         = KIND_PAYLOAD;
		pay_res.payload_byte = byte_in;

		rec_res                = '0;
		rec_res.kind           = KIND_RECORD;
		rec_res.dest_mac       = dmac_n;
		rec_res.source_mac     = smac_n;
		rec_res.ethertype      = etype_n;
		rec_res.source_ipv4    = sip_n;
		rec_res.dest_ipv4      = dip_n;
		rec_res.source_l4_port = sport_n;
		rec_res.dest_l4_port   = dport_n;
		rec_res.ip_proto       = proto_n;
		rec_res.payload_length = cnt_n;
		rec_res.last           = 1'b1;
	end

	// payload item goes first, the record after it
	always_comb begin
		res_b = rec_res;
		if (pay_v) begin
			res_a       = pay_res;
			push.first  = step;
			push.second = step && rec_v;
		end else begin
			res_a       = rec_res;
			push.first  = step && rec_v;
			push.second = 1'b0;
		end
	end

	// frame state, cleared after every final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			drop_q  <= 1'b0;
			dmac_q  <= '0;
			smac_q  <= '0;
			etype_q <= '0;
			hw_q    <= '0;
			proto_q <= '0;
			sip_q   <= '0;
			dip_q   <= '0;
			sport_q <= '0;
			dport_q <= '0;
			cnt_q   <= '0;
		end else if (step) begin
			if (eof) begin
				off_q   <= '0;
				drop_q  <= 1'b0;
				dmac_q  <= '0;
				smac_q  <= '0;
				etype_q <= '0;
				hw_q    <= '0;
				proto_q <= '0;
				sip_q   <= '0;
				dip_q   <= '0;
				sport_q <= '0;
				dport_q <= '0;
				cnt_q   <= '0;
			end else begin
				off_q   <= off_n;
				drop_q  <= drop_n;
				dmac_q  <= dmac_n;
				smac_q  <= smac_n;
				etype_q <= etype_n;
				hw_q    <= hw_n;
				proto_q <= proto_n;
				sip_q   <= sip_n;
				dip_q   <= dip_n;
				sport_q <= sport_n;
				dport_q <= dport_n;
				cnt_q   <= cnt_n;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/ehx_fifo.sv @@
`default_nettype none

module ehx_fifo
	import ehx_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ehx_push_t     push,
	input  wire ehx_result_t   wr_a,
	input  wire ehx_result_t   wr_b,
	input  wire logic          pop,
	output logic [FCNT_W-1:0]  count,
	output ehx_result_t        head
);

	ehx_result_t       mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [FCNT_W-1:0] cnt_q;
	logic [1:0]        n_push;

	assign n_push = {1'b0, push.first} + {1'b0, push.second};
	assign count  = cnt_q;
	assign head   = mem_q[rd_q];

	// entry storage, up to two writes per cycle
	always_ff @(posedge clk) begin
		if (push.first) begin
			mem_q[wr_q] <= wr_a;
		end
		if (push.second) begin
			mem_q[wr_q + PTR_W'(1)] <= wr_b;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(n_push);
			rd_q  <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + FCNT_W'(n_push) - FCNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

@@ rtl/eth_ipv4_l4_header_extractor_top.sv @@
// channel   direction  handshake            payload
// in        receive    in_valid / in_stall   frame_byte, end_of_frame
// out       send       out_valid / out_stall kind, payload_byte, dest_mac, source_mac,
//                                           ethertype, source_ipv4, dest_ipv4,
//                                           source_l4_port, dest_l4_port, ip_proto,
//                                           payload_length, last
//
// one frame byte is taken per cycle while in_stall is low; a result passes the input register
// and the result queue before it leaves. the parser keeps all frame state in registers.
// a final byte may give two results; the 4-entry result queue drains one per cycle if out_stall is low.
// in_stall rises while a byte waits and the queue has fewer than two free entries.
// arst_n clears the frame state, the input stage and the queue pointers.
`default_nettype none

module eth_ipv4_l4_header_extractor_top
	import ehx_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [7:0]       frame_byte,
	input  wire logic             end_of_frame,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  kind,
	output logic [7:0]            payload_byte,
	output logic [47:0]           dest_mac,
	output logic [47:0]           source_mac,
	output logic [15:0]           ethertype,
	output logic [31:0]           source_ipv4,
	output logic [31:0]           dest_ipv4,
	output logic [15:0]           source_l4_port,
	output logic [15:0]           dest_l4_port,
	output logic [7:0]            ip_proto,
	output logic [CNT_W-1:0]      payload_length,
	output logic                  last
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              eof_s1;
	logic              room;
	logic              advance;
	logic              load;
	logic              pop;
	logic [FCNT_W-1:0] fill;
	ehx_push_t         push;
	ehx_result_t       res_a;
	ehx_result_t       res_b;
	ehx_result_t       head;

	// stage handshake: a byte moves on when the queue can take two results
	assign room     = fill <= FCNT_W'(FIFO_DEPTH - 2);
	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign load     = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= frame_byte;
			eof_s1  <= end_of_frame;
		end
	end

	ehx_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.byte_in (byte_s1),
		.eof     (eof_s1),
		.push    (push),
		.res_a   (res_a),
		.res_b   (res_b)
	);

	ehx_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_a   (res_a),
		.wr_b   (res_b),
		.pop    (pop),
		.count  (fill),
		.head   (head)
	);

	// output side
	assign out_valid      = fill != '0;
	assign pop            = out_valid && !out_stall;
	assign kind           = head.kind;
	assign payload_byte   = head.payload_byte;
	assign dest_mac       = head.dest_mac;
	assign source_mac     = head.source_mac;
	assign ethertype      = head.ethertype;
	assign source_ipv4    = head.source_ipv4;
	assign dest_ipv4      = head.dest_ipv4;
	assign source_l4_port = head.source_l4_port;
	assign dest_l4_port   = head.dest_l4_port;
	assign ip_proto       = head.ip_proto;
	assign payload_length = head.payload_length;
	assign last           = head.last;

endmodule

`default_nettype wire
